>>> rtl/d2mf_pkg.sv
// Shared types and constants for the double to minifloat converter.
// No dependencies.
package d2mf_pkg;
   localparam int unsigned DEF_OUT_WIDTH = 64;
   localparam logic [10:0] DBL_BIAS      = 11'd1023;

   typedef enum logic [1:0] {
      STAT_NORMAL    = 2'd0,
      STAT_SUBNORMAL = 2'd1,
      STAT_BAD       = 2'd2
   } status_type;

   typedef struct packed {
      logic [63:0] value_bits;
      logic [3:0]  exp_width;
      logic [5:0]  frac_width;
   } req_type;

   typedef struct packed {
      logic        sign_bit;
      logic [10:0] exp_field;
      logic [51:0] frac_field;
      logic [63:0] packed_word;
      status_type  status;
   } rsp_type;
endpackage

>>> rtl/d2mf_if.sv
// Valid/ready channel carrying one request or result payload.
// Depends on nothing; payload type is a parameter.
interface d2mf_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/d2mf_round.sv
// Combinational conversion core: rebias, round to nearest even, pack.
// Depends on d2mf_pkg.
module d2mf_round #(
   parameter int unsigned OUT_WIDTH = d2mf_pkg::DEF_OUT_WIDTH
) (
   input  d2mf_pkg::req_type req_in,
   output d2mf_pkg::rsp_type rsp_out
);
   import d2mf_pkg::*;

   logic        sgn;
   logic [10:0] e_src;
   logic [51:0] f_src;
   logic [3:0]  ew;
   logic [5:0]  fw;
   logic        bad_w;
   logic [12:0] biased;   // signed-offset: e_src - 1023 + bias, two's complement
   logic [10:0] bias;
   logic [10:0] emax;
   logic [52:0] sig;      // 53-bit source significand aligned for rounding
   logic [5:0]  drop;     // bits removed
   logic [52:0] kept;
   logic [52:0] rest;
   logic [52:0] half;
   logic        rnd_up;
   logic [52:0] kept_r;
   logic        carry;
   logic        subn;
   logic [11:0] exp_out;
   logic [51:0] frac;
   logic [63:0] pk;
   logic [52:0] fmask;

   always_comb begin
      sgn   = req_in.value_bits[63];
      e_src = req_in.value_bits[62:52];
      f_src = req_in.value_bits[51:0];
      ew    = req_in.exp_width;
      fw    = req_in.frac_width;
      bad_w = (ew < 4'd2) || (ew > 4'd11) || (fw < 6'd1) || (fw > 6'd52) ||
              ({3'd0, ew} + {1'b0, fw} + 7'd1 > 7'(OUT_WIDTH)) ||
              (e_src == '0) || (e_src == '1);
      bias   = 11'((12'd1 << (ew - 4'd1)) - 12'd1);
      emax   = 11'((12'd1 << ew) - 12'd1);
      biased = {2'b00, e_src} - {2'b00, DBL_BIAS} + {2'b00, bias};
      subn   = (biased == '0);
      // subnormal rounds 53 bits, normal rounds the 52-bit fraction
      sig    = subn ? {1'b1, f_src} : {1'b0, f_src};
      drop   = subn ? 6'(6'd53 - fw) : 6'(6'd52 - fw);
      fmask  = (53'd1 << fw) - 53'd1;
      kept   = sig >> drop;
      rest   = sig & ((53'd1 << drop) - 53'd1);
      half   = (drop == '0) ? '0 : (53'd1 << (drop - 6'd1));
      rnd_up = (drop != '0) && ((rest > half) || ((rest == half) && kept[0]));
      kept_r = kept + {52'd0, rnd_up};
      carry  = ((kept_r & ~fmask) != '0);
      frac   = carry ? '0 : kept_r[51:0];
      exp_out = {1'b0, biased[10:0]} + {11'd0, carry};

      rsp_out = '0;
      rsp_out.status = STAT_BAD;
      if (!bad_w && !biased[12] && !(exp_out > {1'b0, emax})) begin
         rsp_out.sign_bit   = sgn;
         rsp_out.exp_field  = exp_out[10:0];
         rsp_out.frac_field = frac;
         pk = ({63'd0, sgn} << ({2'd0, ew} + fw)) |
              ({53'd0, exp_out[10:0]} << fw) | {12'd0, frac};
         rsp_out.packed_word = pk;
         rsp_out.status = (subn && !carry) ? STAT_SUBNORMAL : STAT_NORMAL;
      end else begin
         pk = '0;
      end
   end
endmodule

>>> rtl/double_to_minifloat_convert.sv
// Top level: double to minifloat converter with input and result registers.
// Depends on d2mf_pkg, d2mf_if, d2mf_round.
//
// Usage: requests enter on req (valid/ready), carrying a double bit pattern
// and the target exponent and fraction widths. Results leave on rsp with
// sign, exponent, fraction, packed word and status.
// Path: an accepted request is held in the input register, passes through
// the conversion logic and is captured in the result register, which
// drives rsp.valid.
// Throughput: one request per cycle while rsp.ready stays high; the two
// registers advance together, so back to back requests need no gap.
// Reset: clears both valid flags; no request is held.
// Stall: when rsp.ready is low the result register holds, the input
// register holds behind it and req.ready drops only when both are full.
module double_to_minifloat_convert #(
   parameter int unsigned OUT_WIDTH = d2mf_pkg::DEF_OUT_WIDTH
) (
   input logic   clock,
   input logic   reset,
   d2mf_if.sink   req,
   d2mf_if.source rsp
);
   import d2mf_pkg::*;

   logic    in_vld_ff, in_vld_in;
   req_type in_ff;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff;
   rsp_type conv;
   logic    adv;

   d2mf_round #(.OUT_WIDTH(OUT_WIDTH)) u_round (.req_in(in_ff), .rsp_out(conv));

   // advance the stage when the result register is free or being drained
   assign adv        = !out_vld_ff || rsp.ready;
   assign req.ready  = !in_vld_ff || adv;
   assign in_vld_in  = req.valid ? 1'b1 : (adv ? 1'b0 : in_vld_ff);
   assign out_vld_in = adv ? in_vld_ff : out_vld_ff;
   assign rsp.valid  = out_vld_ff;
   assign rsp.payload = out_ff;

   // hold control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= req.ready ? in_vld_in : in_vld_ff;
         out_vld_ff <= out_vld_in;
      end
   end

   // load payloads
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_ff <= req.payload;
      if (adv && in_vld_ff) out_ff <= conv;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp.ready |=> out_vld_ff && $stable(out_ff))
      else $error("result dropped under stall");
   a_move: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && adv |=> out_vld_ff)
      else $error("request lost between stages");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && out_ff.status == STAT_BAD |-> out_ff.packed_word == '0)
      else $error("bad status with nonzero word");
endmodule

>>> sim/tb_double_to_minifloat_convert.sv
// Testbench for double_to_minifloat_convert: directed and random requests,
// each result checked field by field against a local rounding predictor.
// Depends on d2mf_pkg, d2mf_if and the converter RTL.
module tb_double_to_minifloat_convert;
   import d2mf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WATCHDOG_LIMIT = 5000;

   logic clock;
   logic reset;

   d2mf_if #(.payload_type(req_type)) req_ch ();
   d2mf_if #(.payload_type(rsp_type)) rsp_ch ();

   double_to_minifloat_convert uut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch.sink),
      .rsp  (rsp_ch.source)
   );

   rsp_type     expected_q[$];
   int unsigned error_count;
   int unsigned idle_cycles;

   // Generate the clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Return a mask of the n low bits
   function automatic logic [63:0] ones(int unsigned n);
      if (n >= 64) begin
         return '1;
      end
      return (64'd1 << n) - 64'd1;
   endfunction

   // Predict the converted minifloat for one request
   function automatic rsp_type convert_double(req_type r);
      rsp_type     res;
      logic [10:0] e_src;
      logic [51:0] f_src;
      int          ew, fw, drop;
      longint      biased;
      logic [63:0] sig, kept, rest, half, exp_out;
      int          width;
      bit          carry;
      res = '0;
      res.status = STAT_BAD;
      ew = r.exp_width;
      fw = r.frac_width;
      e_src = r.value_bits[62:52];
      f_src = r.value_bits[51:0];
      if (ew < 2 || ew > 11 || fw < 1 || fw > 52 || 1 + ew + fw > 64 ||
          e_src == 11'd0 || e_src == 11'h7ff) begin
         return res;
      end
      biased = longint'(e_src) - 1023 + ((64'sd1 <<< (ew - 1)) - 1);
      if (biased < 0) begin
         return res;
      end
      carry = 1'b0;
      if (biased == 0 || fw != 52) begin
         // Round to nearest, ties to even, sticky over all dropped bits
         width = (biased == 0) ? 53 : 52;
         sig = (biased == 0) ? ({11'd0, 1'b1, f_src}) : {12'd0, f_src};
         drop = width - fw;
         kept = sig >> drop;
         rest = sig & ones(drop);
         half = 64'd1 << (drop - 1);
         if (rest > half || (rest == half && kept[0])) begin
            kept = kept + 64'd1;
         end
         if ((kept >> fw) != 0) begin
            kept = '0;
            carry = 1'b1;
         end
      end else begin
         kept = {12'd0, f_src};
      end
      if (biased == 0) begin
         exp_out = carry ? 64'd1 : 64'd0;
         res.status = carry ? STAT_NORMAL : STAT_SUBNORMAL;
      end else begin
         exp_out = 64'(biased) + (carry ? 64'd1 : 64'd0);
         if (exp_out > ones(ew)) begin
            return res;
         end
         res.status = STAT_NORMAL;
      end
      res.sign_bit    = r.value_bits[63];
      res.exp_field   = exp_out[10:0];
      res.frac_field  = kept[51:0];
      res.packed_word = (64'(r.value_bits[63]) << (ew + fw)) | (exp_out << fw) | kept;
      return res;
   endfunction

   // Print one mismatch line and count it
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
   endtask

   // Return a gap length: mostly short, sometimes long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 50) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(30, 8);
   endfunction

   // Send one request and record its predicted result; valid stays high
   // into the next request when there is no gap
   task automatic send_request(logic [63:0] v, logic [3:0] ew, logic [5:0] fw);
      req_type r;
      int unsigned gap;
      r.value_bits = v;
      r.exp_width  = ew;
      r.frac_width = fw;
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(convert_double(r));
   endtask

   // Build a double with a chosen exponent and random sign and fraction
   function automatic logic [63:0] rand_double(logic [10:0] e);
      return {1'($urandom), e, 20'($urandom), 32'($urandom)};
   endfunction

   // Directed cases: field extremes and each special case
   task automatic test_directed();
      send_request(64'h0000_0000_0000_0000, 4'd5, 6'd10);
      send_request(64'h8000_0000_0000_0001, 4'd5, 6'd10);
      send_request(64'h7ff0_0000_0000_0000, 4'd5, 6'd10);
      send_request(64'hfff8_0000_0000_0000, 4'd8, 6'd23);
      send_request(64'h3ff0_0000_0000_0000, 4'd1, 6'd10);
      send_request(64'h3ff0_0000_0000_0000, 4'd12, 6'd10);
      send_request(64'h3ff0_0000_0000_0000, 4'd15, 6'd63);
      send_request(64'h3ff0_0000_0000_0000, 4'd5, 6'd0);
      send_request(64'h3ff0_0000_0000_0000, 4'd11, 6'd52);
      send_request(64'hbfff_ffff_ffff_ffff, 4'd11, 6'd52);
      send_request(64'h3ff8_0000_0000_0000, 4'd2, 6'd1);
      send_request(64'h3ff4_0000_0000_0000, 4'd2, 6'd1);
      send_request(64'h3ffc_0000_0000_0000, 4'd2, 6'd1);
      send_request(64'h3ffc_0000_0000_0001, 4'd3, 6'd1);
      // Lowest normal exponent, a carry into the next exponent, and a subnormal rounding up to normal
      send_request(64'h3f10_0000_0000_0000, 4'd5, 6'd10);
      send_request(64'h3f1f_ffff_ffff_ffff, 4'd5, 6'd10);
      send_request(64'h3f0f_ffff_ffff_ffff, 4'd5, 6'd10);
      // High exponents, a carry into the next exponent, and the all-ones exponent
      send_request(64'h40ef_f000_0000_0000, 4'd5, 6'd10);
      send_request(64'h40ef_ffff_ffff_ffff, 4'd5, 6'd10);
      send_request(64'h40f0_0000_0000_0000, 4'd5, 6'd10);
      send_request(64'hffef_ffff_ffff_ffff, 4'd11, 6'd51);
      send_request(64'h0010_0000_0000_0000, 4'd11, 6'd20);
      send_request(64'h5555_5555_5555_5555, 4'd11, 6'd52);
      send_request(64'haaaa_aaaa_aaaa_aaaa, 4'd10, 6'd40);
   endtask

   // Random requests, mostly valid widths near the target range
   task automatic test_random(int unsigned count);
      logic [63:0] v;
      logic [3:0]  ew;
      logic [5:0]  fw;
      logic [63:0] tail;
      int          bias_t, e;
      repeat (count) begin
         if ($urandom_range(9) == 0) begin
            ew = 4'($urandom);
            fw = 6'($urandom);
            v  = {32'($urandom), 32'($urandom)};
         end else begin
            ew = 4'($urandom_range(11, 2));
            fw = ($urandom_range(3) == 0) ? 6'($urandom_range(52, 40))
                                         : 6'($urandom_range(24, 1));
            bias_t = (1 << (ew - 1)) - 1;
            e = 1023 - bias_t + $urandom_range((1 << ew) + 1) - 1;
            if (e < 1) e = 1;
            if (e > 2046) e = 2046;
            v = rand_double(11'(e));
            // Sometimes force an exact tie or an all-ones tail below the kept bits
            if ($urandom_range(7) == 0 && fw < 6'd52) begin
               tail = ones(52 - fw);
               if ($urandom_range(1) == 0) begin
                  v[51:0] = (v[51:0] & ~tail[51:0]) | (tail[51:0] ^ (tail[51:0] >> 1));
               end else begin
                  v[51:0] = v[51:0] | tail[51:0];
               end
            end
         end
         send_request(v, ew, fw);
      end
   endtask

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", got.packed_word, '0);
         end else begin
            want = expected_q.pop_front();
            if (got.sign_bit !== want.sign_bit)
               report_mismatch("sign_bit", 64'(got.sign_bit), 64'(want.sign_bit));
            if (got.exp_field !== want.exp_field)
               report_mismatch("exp_field", 64'(got.exp_field), 64'(want.exp_field));
            if (got.frac_field !== want.frac_field)
               report_mismatch("frac_field", 64'(got.frac_field), 64'(want.frac_field));
            if (got.packed_word !== want.packed_word)
               report_mismatch("packed_word", got.packed_word, want.packed_word);
            if (got.status !== want.status)
               report_mismatch("status", 64'(got.status), 64'(want.status));
         end
      end
   end

   // Stall the result side at random, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(199) < 2) begin
         rsp_ch.ready <= 1'b0;
      end else if (!rsp_ch.ready && $urandom_range(3) == 0) begin
         rsp_ch.ready <= 1'b1;
      end else if (rsp_ch.ready && $urandom_range(9) == 0) begin
         rsp_ch.ready <= 1'b0;
      end else if (!rsp_ch.ready && $urandom_range(1) == 0) begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog: count cycles with no accepted request or result
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1300);
      req_ch.valid <= 1'b0;
      // Drain remaining results, then let the pipeline settle
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/d2mf_pkg.sv
rtl/d2mf_if.sv
rtl/d2mf_round.sv
rtl/double_to_minifloat_convert.sv
sim/tb_double_to_minifloat_convert.sv
